[rtl/gceb_pkg.sv]
package gceb_pkg;

  localparam int MAX_GLYPH_SIZE_DEFAULT = 32;
  localparam int COORD_BITS_DEFAULT = 12;

  localparam int BYTE_W = 8;
  localparam int COLOR_W = 24;
  localparam int ADDR_W = 24;
  localparam int DIM_W = 13;
  localparam int SIZE_FIELD_W = 6;
  localparam int CFG_INDEX_W = 3;
  localparam int OUT_DATA_W = ADDR_W + COLOR_W;
  localparam int GROUP_SHIFT = 3;

  localparam logic [2:0] GROUP_PIXELS = 3'h7;

  localparam logic [CFG_INDEX_W-1:0] REG_TEXT_COLOR = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BACKGROUND_COLOR = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TRANSPARENT_BACKGROUND = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BUFFER_WIDTH = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_BUFFER_HEIGHT = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SCANLINE_PIXELS = 3'd5;

  localparam logic [COLOR_W-1:0] TEXT_COLOR_RESET = 24'hcccccc;

  typedef struct packed {
    logic [COLOR_W-1:0] text_color;
    logic [COLOR_W-1:0] background_color;
    logic               transparent_background;
    logic [DIM_W-1:0]   buffer_width;
    logic [DIM_W-1:0]   buffer_height;
    logic [DIM_W-1:0]   scanline_pixels;
  } cfg_t;

  // Width of a clamped glyph size, which may equal the maximum itself.
  function automatic int size_bits(input int max_size);
    return $clog2(max_size + 1);
  endfunction

  // Width of the column group counter; it also holds the group count.
  function automatic int group_bits(input int max_size);
    return $clog2(max_size) - 2;
  endfunction

  // Width of the first pixel offset of a column group.
  function automatic int rel_bits(input int max_size);
    return group_bits(max_size) + GROUP_SHIFT;
  endfunction

  // Width of the x position of a group's first pixel, with headroom for the byte.
  function automatic int x_bits(input int coord_bits, input int max_size);
    return ((coord_bits > rel_bits(max_size)) ? coord_bits : rel_bits(max_size)) + 2;
  endfunction

endpackage

[rtl/gceb_cfg_regs.sv]
module gceb_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gceb_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [gceb_pkg::COLOR_W-1:0]        cfg_data,
  output gceb_pkg::cfg_t                      cfg
);

  gceb_pkg::cfg_t regs;

  assign cfg_ready = 1'b1;
  assign cfg = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.text_color <= gceb_pkg::TEXT_COLOR_RESET;
      regs.background_color <= '0;
      regs.transparent_background <= 1'b0;
      regs.buffer_width <= '0;
      regs.buffer_height <= '0;
      regs.scanline_pixels <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gceb_pkg::REG_TEXT_COLOR: begin
          regs.text_color <= cfg_data;
        end
        gceb_pkg::REG_BACKGROUND_COLOR: begin
          regs.background_color <= cfg_data;
        end
        gceb_pkg::REG_TRANSPARENT_BACKGROUND: begin
          regs.transparent_background <= cfg_data[0];
        end
        gceb_pkg::REG_BUFFER_WIDTH: begin
          regs.buffer_width <= cfg_data[gceb_pkg::DIM_W-1:0];
        end
        gceb_pkg::REG_BUFFER_HEIGHT: begin
          regs.buffer_height <= cfg_data[gceb_pkg::DIM_W-1:0];
        end
        gceb_pkg::REG_SCANLINE_PIXELS: begin
          regs.scanline_pixels <= cfg_data[gceb_pkg::DIM_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[rtl/gceb_glyph_walk.sv]
module gceb_glyph_walk #(
  parameter int MAX_GLYPH_SIZE = gceb_pkg::MAX_GLYPH_SIZE_DEFAULT,
  parameter int COORD_BITS = gceb_pkg::COORD_BITS_DEFAULT
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        in_valid,
  output logic                                        in_ready,
  input  logic [gceb_pkg::BYTE_W-1:0]                 glyph_byte,
  input  logic [COORD_BITS-1:0]                       origin_x,
  input  logic [COORD_BITS-1:0]                       origin_y,
  input  logic [gceb_pkg::SIZE_FIELD_W-1:0]           glyph_width,
  input  logic [gceb_pkg::SIZE_FIELD_W-1:0]           glyph_height,
  input  logic                                        first_byte,
  output logic                                        s1_valid,
  input  logic                                        s1_ready,
  output logic [gceb_pkg::BYTE_W-1:0]                 s1_bits,
  output logic [COORD_BITS-1:0]                       s1_ox,
  output logic [COORD_BITS:0]                         s1_dy,
  output logic [gceb_pkg::size_bits(MAX_GLYPH_SIZE)-1:0] s1_width,
  output logic [gceb_pkg::rel_bits(MAX_GLYPH_SIZE)-1:0]  s1_rel0
);

  localparam int SIZE_W = gceb_pkg::size_bits(MAX_GLYPH_SIZE);
  localparam int GRP_W = gceb_pkg::group_bits(MAX_GLYPH_SIZE);
  localparam int ROW_W = $clog2(MAX_GLYPH_SIZE);
  localparam int DY_W = COORD_BITS + 1;

  logic [GRP_W-1:0]  column_group;
  logic [ROW_W-1:0]  row_index;
  logic [GRP_W-1:0]  column_group_next;
  logic [ROW_W-1:0]  row_index_next;

  logic              accept;
  logic [7:0]        width_ext;
  logic [7:0]        height_ext;
  logic [SIZE_W-1:0] width_c;
  logic [SIZE_W-1:0] height_c;
  logic [GRP_W-1:0]  group_cur;
  logic [ROW_W-1:0]  row_cur;
  logic [SIZE_W:0]   group_sum;
  logic [SIZE_W:0]   groups;
  logic [SIZE_W-1:0] rows;
  logic [SIZE_W-1:0] row_inc;
  logic [SIZE_W:0]   group_inc;

  assign in_ready = !s1_valid || s1_ready;
  assign accept = in_valid && in_ready;

  always_comb begin
    width_ext = {2'b00, glyph_width};
    height_ext = {2'b00, glyph_height};
    width_c = (width_ext > 8'(MAX_GLYPH_SIZE)) ? SIZE_W'(MAX_GLYPH_SIZE)
                                                : width_ext[SIZE_W-1:0];
    height_c = (height_ext > 8'(MAX_GLYPH_SIZE)) ? SIZE_W'(MAX_GLYPH_SIZE)
                                                  : height_ext[SIZE_W-1:0];
    group_cur = first_byte ? '0 : column_group;
    row_cur = first_byte ? '0 : row_index;

    group_sum = {1'b0, width_c} + (SIZE_W+1)'(gceb_pkg::GROUP_PIXELS);
    groups = group_sum >> gceb_pkg::GROUP_SHIFT;
    if (groups == '0) begin
      groups = (SIZE_W+1)'(1);
    end
    rows = (height_c == '0) ? SIZE_W'(1) : height_c;

    row_inc = SIZE_W'(row_cur) + SIZE_W'(1);
    group_inc = (SIZE_W+1)'(group_cur) + (SIZE_W+1)'(1);
    if (row_inc >= rows) begin
      row_index_next = '0;
      column_group_next = (group_inc >= groups) ? '0 : GRP_W'(group_inc);
    end else begin
      row_index_next = ROW_W'(row_inc);
      column_group_next = group_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_group <= '0;
      row_index <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (accept) begin
        column_group <= column_group_next;
        row_index <= row_index_next;
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_ready) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_bits <= glyph_byte;
      s1_ox <= origin_x;
      s1_dy <= DY_W'(origin_y) + DY_W'(row_cur);
      s1_width <= width_c;
      s1_rel0 <= {group_cur, 3'b000};
    end
  end

endmodule

[rtl/gceb_clip_stage.sv]
module gceb_clip_stage #(
  parameter int MAX_GLYPH_SIZE = gceb_pkg::MAX_GLYPH_SIZE_DEFAULT,
  parameter int COORD_BITS = gceb_pkg::COORD_BITS_DEFAULT
) (
  input  logic                                           clk,
  input  logic                                           rst,
  input  gceb_pkg::cfg_t                                 cfg,
  input  logic                                           s1_valid,
  output logic                                           s1_ready,
  input  logic [gceb_pkg::BYTE_W-1:0]                    s1_bits,
  input  logic [COORD_BITS-1:0]                          s1_ox,
  input  logic [COORD_BITS:0]                            s1_dy,
  input  logic [gceb_pkg::size_bits(MAX_GLYPH_SIZE)-1:0] s1_width,
  input  logic [gceb_pkg::rel_bits(MAX_GLYPH_SIZE)-1:0]  s1_rel0,
  output logic                                           s2_valid,
  input  logic                                           s2_ready,
  output logic [gceb_pkg::BYTE_W-1:0]                    s2_mask,
  output logic [gceb_pkg::BYTE_W-1:0]                    s2_set,
  output logic [gceb_pkg::x_bits(COORD_BITS, MAX_GLYPH_SIZE)-1:0] s2_x0,
  output logic [gceb_pkg::ADDR_W-1:0]                    s2_row_base
);

  localparam int X_W = gceb_pkg::x_bits(COORD_BITS, MAX_GLYPH_SIZE);
  localparam int CMP_W = (X_W > gceb_pkg::DIM_W) ? X_W : gceb_pkg::DIM_W;
  localparam int DY_W = COORD_BITS + 1;
  localparam int DYC_W = (DY_W > gceb_pkg::DIM_W) ? DY_W : gceb_pkg::DIM_W;
  localparam int PROD_W = DY_W + gceb_pkg::DIM_W;

  logic                        load;
  logic                        row_ok;
  logic [CMP_W-1:0]            rel_k;
  logic [CMP_W-1:0]            dx_k;
  logic [gceb_pkg::BYTE_W-1:0] mask;
  logic [gceb_pkg::BYTE_W-1:0] set;
  logic [PROD_W-1:0]           product;

  assign s1_ready = !s2_valid || s2_ready;
  assign load = s1_valid && s1_ready;

  always_comb begin
    row_ok = DYC_W'(s1_dy) < DYC_W'(cfg.buffer_height);
    mask = '0;
    set = '0;
    rel_k = '0;
    dx_k = '0;
    for (int k = 0; k < gceb_pkg::BYTE_W; k++) begin
      rel_k = CMP_W'(s1_rel0) + CMP_W'(k);
      dx_k = CMP_W'(s1_ox) + rel_k;
      set[k] = s1_bits[gceb_pkg::BYTE_W-1-k];
      mask[k] = (rel_k < CMP_W'(s1_width)) && (dx_k < CMP_W'(cfg.buffer_width)) && row_ok
                && (set[k] || !cfg.transparent_background);
    end
    product = PROD_W'(s1_dy) * PROD_W'(cfg.scanline_pixels);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (load) begin
      s2_valid <= 1'b1;
    end else if (s2_ready) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s2_mask <= mask;
      s2_set <= set;
      s2_x0 <= X_W'(s1_ox) + X_W'(s1_rel0);
      s2_row_base <= gceb_pkg::ADDR_W'(product);
    end
  end

endmodule

[rtl/gceb_pixel_emit.sv]
module gceb_pixel_emit #(
  parameter int MAX_GLYPH_SIZE = gceb_pkg::MAX_GLYPH_SIZE_DEFAULT,
  parameter int COORD_BITS = gceb_pkg::COORD_BITS_DEFAULT
) (
  input  logic                                                    clk,
  input  logic                                                    rst,
  input  gceb_pkg::cfg_t                                          cfg,
  input  logic                                                    s2_valid,
  output logic                                                    s2_ready,
  input  logic [gceb_pkg::BYTE_W-1:0]                             s2_mask,
  input  logic [gceb_pkg::BYTE_W-1:0]                             s2_set,
  input  logic [gceb_pkg::x_bits(COORD_BITS, MAX_GLYPH_SIZE)-1:0] s2_x0,
  input  logic [gceb_pkg::ADDR_W-1:0]                             s2_row_base,
  output logic                                                    m_axis_tvalid,
  input  logic                                                    m_axis_tready,
  output logic [gceb_pkg::OUT_DATA_W-1:0]                         m_axis_tdata,
  output logic                                                    m_axis_tlast
);

  localparam int IDX_W = $clog2(gceb_pkg::BYTE_W);

  logic [gceb_pkg::BYTE_W-1:0]  pend;
  logic [gceb_pkg::BYTE_W-1:0]  pend_set;
  logic [gceb_pkg::ADDR_W-1:0]  base;
  logic [gceb_pkg::ADDR_W-1:0]  out_addr;
  logic [gceb_pkg::COLOR_W-1:0] out_color;
  logic                         out_last;

  logic                         out_open;
  logic                         active;
  logic                         step;
  logic                         take;
  logic [gceb_pkg::BYTE_W-1:0]  pick;
  logic [gceb_pkg::BYTE_W-1:0]  pend_next;
  logic [IDX_W-1:0]             pick_idx;

  always_comb begin
    pick = pend & (~pend + gceb_pkg::BYTE_W'(1));
    pend_next = pend & ~pick;
    pick_idx = '0;
    for (int k = 0; k < gceb_pkg::BYTE_W; k++) begin
      if (pick[k]) begin
        pick_idx = IDX_W'(k);
      end
    end
  end

  assign out_open = !m_axis_tvalid || m_axis_tready;
  assign active = |pend;
  assign step = active && out_open;
  assign s2_ready = !active || (step && (pend_next == '0));
  assign take = s2_valid && s2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (take) begin
        pend <= s2_mask;
      end else if (step) begin
        pend <= pend_next;
      end
      if (out_open) begin
        m_axis_tvalid <= step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pend_set <= s2_set;
      base <= s2_row_base + gceb_pkg::ADDR_W'(s2_x0);
    end
    if (step) begin
      out_addr <= base + gceb_pkg::ADDR_W'(pick_idx);
      out_color <= pend_set[pick_idx] ? cfg.text_color : cfg.background_color;
      out_last <= (pend_next == '0);
    end
  end

  assign m_axis_tdata = {out_color, out_addr};
  assign m_axis_tlast = out_last;

endmodule

[rtl/glyph_color_expand_blitter_core.sv]
// Channel   Direction  Word                                                  Handshake
// s_axis    in         tdata: glyph byte, x, y, width, height; tuser: first  tvalid/tready
// m_axis    out        tdata: pixel address, pixel color; tlast: last write  tvalid/tready
// cfg       in         cfg_index: register, cfg_data: value                  cfg_valid/cfg_ready
//
// A glyph byte passes a counter stage and a clip and multiply stage, then the
// emitter sends its visible pixels, up to eight, one pixel write per cycle while
// m_axis accepts them; a byte with no visible pixels sends no write.
// The emitter and its output register set the rate; input words are taken while
// earlier writes are still pending. Reset clears the counters, the config registers and
// all valid flags. Backpressure on m_axis stalls the stages one after another.
module glyph_color_expand_blitter_core #(
  parameter int MAX_GLYPH_SIZE = gceb_pkg::MAX_GLYPH_SIZE_DEFAULT,
  parameter int COORD_BITS = gceb_pkg::COORD_BITS_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // glyph_byte, origin_x, origin_y, glyph_width, glyph_height, zero fill
  input  logic [((2*COORD_BITS+20+7)/8)*8-1:0]   s_axis_tdata,
  // first_byte
  input  logic [0:0]                             s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // pixel_address, pixel_color
  output logic [gceb_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
  output logic                                   m_axis_tlast,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [gceb_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [gceb_pkg::COLOR_W-1:0]           cfg_data
);

  localparam int SIZE_W = gceb_pkg::size_bits(MAX_GLYPH_SIZE);
  localparam int REL_W = gceb_pkg::rel_bits(MAX_GLYPH_SIZE);
  localparam int X_W = gceb_pkg::x_bits(COORD_BITS, MAX_GLYPH_SIZE);
  localparam int OX_LSB = gceb_pkg::BYTE_W;
  localparam int OY_LSB = OX_LSB + COORD_BITS;
  localparam int GW_LSB = OY_LSB + COORD_BITS;
  localparam int GH_LSB = GW_LSB + gceb_pkg::SIZE_FIELD_W;

  gceb_pkg::cfg_t              cfg;

  logic                        s1_valid;
  logic                        s1_ready;
  logic [gceb_pkg::BYTE_W-1:0] s1_bits;
  logic [COORD_BITS-1:0]       s1_ox;
  logic [COORD_BITS:0]         s1_dy;
  logic [SIZE_W-1:0]           s1_width;
  logic [REL_W-1:0]            s1_rel0;

  logic                        s2_valid;
  logic                        s2_ready;
  logic [gceb_pkg::BYTE_W-1:0] s2_mask;
  logic [gceb_pkg::BYTE_W-1:0] s2_set;
  logic [X_W-1:0]              s2_x0;
  logic [gceb_pkg::ADDR_W-1:0] s2_row_base;

  gceb_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  gceb_glyph_walk #(
    .MAX_GLYPH_SIZE (MAX_GLYPH_SIZE),
    .COORD_BITS     (COORD_BITS)
  ) u_walk (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .glyph_byte   (s_axis_tdata[gceb_pkg::BYTE_W-1:0]),
    .origin_x     (s_axis_tdata[OX_LSB +: COORD_BITS]),
    .origin_y     (s_axis_tdata[OY_LSB +: COORD_BITS]),
    .glyph_width  (s_axis_tdata[GW_LSB +: gceb_pkg::SIZE_FIELD_W]),
    .glyph_height (s_axis_tdata[GH_LSB +: gceb_pkg::SIZE_FIELD_W]),
    .first_byte   (s_axis_tuser[0]),
    .s1_valid     (s1_valid),
    .s1_ready     (s1_ready),
    .s1_bits      (s1_bits),
    .s1_ox        (s1_ox),
    .s1_dy        (s1_dy),
    .s1_width     (s1_width),
    .s1_rel0      (s1_rel0)
  );

  gceb_clip_stage #(
    .MAX_GLYPH_SIZE (MAX_GLYPH_SIZE),
    .COORD_BITS     (COORD_BITS)
  ) u_clip (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .s1_valid    (s1_valid),
    .s1_ready    (s1_ready),
    .s1_bits     (s1_bits),
    .s1_ox       (s1_ox),
    .s1_dy       (s1_dy),
    .s1_width    (s1_width),
    .s1_rel0     (s1_rel0),
    .s2_valid    (s2_valid),
    .s2_ready    (s2_ready),
    .s2_mask     (s2_mask),
    .s2_set      (s2_set),
    .s2_x0       (s2_x0),
    .s2_row_base (s2_row_base)
  );

  gceb_pixel_emit #(
    .MAX_GLYPH_SIZE (MAX_GLYPH_SIZE),
    .COORD_BITS     (COORD_BITS)
  ) u_emit (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .s2_valid      (s2_valid),
    .s2_ready      (s2_ready),
    .s2_mask       (s2_mask),
    .s2_set        (s2_set),
    .s2_x0         (s2_x0),
    .s2_row_base   (s2_row_base),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  a_ready_only_on_backpressure: assert property (
    @(posedge clk) disable iff (rst) !s_axis_tready |-> s1_valid
  ) else $error("input refused while the first stage is empty");

  a_stalled_stage_keeps_word: assert property (
    @(posedge clk) disable iff (rst) s1_valid && !s1_ready |=> s1_valid
  ) else $error("first stage dropped a stalled word");

  a_stage_handoff: assert property (
    @(posedge clk) disable iff (rst) s1_valid && s1_ready |=> s2_valid
  ) else $error("word lost between the first and second stage");

endmodule

[tb/sv/tb_glyph_color_expand_blitter_core.sv]
module tb_glyph_color_expand_blitter_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GLYPH_MAX = gceb_pkg::MAX_GLYPH_SIZE_DEFAULT;
  localparam int IN_DATA_W = ((2*gceb_pkg::COORD_BITS_DEFAULT+20+7)/8)*8;
  localparam int DRAIN_CYCLES = 32;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_AT_WRITE = 300;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_WORDS = 97;

  typedef struct {
    logic [gceb_pkg::BYTE_W-1:0]       bits;
    logic [11:0]                       x;
    logic [11:0]                       y;
    logic [gceb_pkg::SIZE_FIELD_W-1:0] w;
    logic [gceb_pkg::SIZE_FIELD_W-1:0] h;
    logic                              first;
  } glyph_word_t;

  typedef struct {
    logic [gceb_pkg::ADDR_W-1:0]  addr;
    logic [gceb_pkg::COLOR_W-1:0] color;
    logic                         last;
  } pixel_write_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic [0:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [gceb_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic m_axis_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [gceb_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [gceb_pkg::COLOR_W-1:0] cfg_data = '0;

  // Predictor copy of the registers and the bitmap position.
  logic [gceb_pkg::COLOR_W-1:0] text_rgb = gceb_pkg::TEXT_COLOR_RESET;
  logic [gceb_pkg::COLOR_W-1:0] back_rgb = '0;
  logic                         see_through = 1'b0;
  logic [gceb_pkg::DIM_W-1:0]   clip_w = '0;
  logic [gceb_pkg::DIM_W-1:0]   clip_h = '0;
  logic [gceb_pkg::DIM_W-1:0]   pitch = '0;
  int unsigned                  col_group = 0;
  int unsigned                  row_pos = 0;

  glyph_word_t  glyph_words[$];
  pixel_write_t pending_pixels[$];

  int  failures = 0;
  int  writes_seen = 0;
  int  idle_cycles = 0;
  bit  in_taken = 1'b0;
  bit  out_taken = 1'b0;
  int  in_wait = 0;
  int  in_quiet = 0;
  int  out_wait = 0;
  int  out_quiet = 0;
  int  hold_left = 0;

  glyph_color_expand_blitter_core dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void note_failure(input string msg);
    failures++;
    if (failures <= 10) $display("%s", msg);
  endfunction

  function automatic int draw_wait(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) quiet = $urandom_range(10, 30);
    return $urandom_range(0, 15);
  endfunction

  // Expands one bitmap byte into the pixel writes it should produce.
  function automatic void expand_glyph_byte(input glyph_word_t g);
    pixel_write_t burst[8];
    int unsigned  wd, ht, groups, rows, rel, dx, dy;
    int           n;
    logic [gceb_pkg::COLOR_W-1:0] rgb;
    wd = (g.w > GLYPH_MAX) ? GLYPH_MAX : g.w;
    ht = (g.h > GLYPH_MAX) ? GLYPH_MAX : g.h;
    if (g.first) begin
      col_group = 0;
      row_pos = 0;
    end
    dy = g.y + row_pos;
    n = 0;
    for (int k = 0; k < 8; k++) begin
      rel = k + (col_group << gceb_pkg::GROUP_SHIFT);
      dx = g.x + rel;
      if (rel >= wd || dx >= clip_w || dy >= clip_h) break;
      if (g.bits[7-k]) rgb = text_rgb;
      else if (!see_through) rgb = back_rgb;
      else continue;
      burst[n].addr = gceb_pkg::ADDR_W'(dx + dy * pitch);
      burst[n].color = rgb;
      burst[n].last = 1'b0;
      n++;
    end
    if (n > 0) burst[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) pending_pixels.push_back(burst[i]);
    groups = (wd + 7) >> gceb_pkg::GROUP_SHIFT;
    if (groups == 0) groups = 1;
    rows = (ht != 0) ? ht : 1;
    row_pos++;
    if (row_pos >= rows) begin
      row_pos = 0;
      col_group++;
      if (col_group >= groups) col_group = 0;
    end
  endfunction

  always @(posedge clk) begin
    pixel_write_t want;
    glyph_word_t  g;
    in_taken = s_axis_tvalid && s_axis_tready;
    out_taken = m_axis_tvalid && m_axis_tready;
    if (!rst) begin
      if (in_taken) begin
        g.bits = s_axis_tdata[7:0];
        g.x = s_axis_tdata[19:8];
        g.y = s_axis_tdata[31:20];
        g.w = s_axis_tdata[37:32];
        g.h = s_axis_tdata[43:38];
        g.first = s_axis_tuser[0];
        expand_glyph_byte(g);
      end
      if (out_taken) begin
        writes_seen++;
        if (pending_pixels.size() == 0) begin
          note_failure($sformatf("unexpected pixel write: addr %h color %h last %b",
                                 m_axis_tdata[23:0], m_axis_tdata[47:24], m_axis_tlast));
        end else begin
          want = pending_pixels.pop_front();
          if (m_axis_tdata[23:0] !== want.addr || m_axis_tdata[47:24] !== want.color ||
              m_axis_tlast !== want.last)
            note_failure($sformatf(
              "pixel write %0d: expected addr %h color %h last %b, got addr %h color %h last %b",
              writes_seen, want.addr, want.color, want.last,
              m_axis_tdata[23:0], m_axis_tdata[47:24], m_axis_tlast));
        end
      end
      if (in_taken || out_taken || (cfg_valid && cfg_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    glyph_word_t g;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (in_taken) in_wait = draw_wait(in_quiet);
      if (in_wait > 0) begin
        in_wait--;
        s_axis_tvalid <= 1'b0;
      end else if (glyph_words.size() > 0) begin
        g = glyph_words.pop_front();
        s_axis_tdata <= {4'b0, g.h, g.w, g.y, g.x, g.bits};
        s_axis_tuser <= g.first;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // The long hold lets the block fill up while the sender keeps offering words.
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (out_taken) begin
        out_wait = draw_wait(out_quiet);
        if (writes_seen == HOLD_AT_WRITE) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (out_wait > 0) begin
        out_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic void queue_word(input logic [7:0] bits, input int x, input int y,
                                     input int w, input int h, input bit first);
    glyph_word_t g;
    g.bits = bits;
    g.x = 12'(x);
    g.y = 12'(y);
    g.w = gceb_pkg::SIZE_FIELD_W'(w);
    g.h = gceb_pkg::SIZE_FIELD_W'(h);
    g.first = first;
    glyph_words.push_back(g);
  endfunction

  function automatic int pick_glyph_size(input int common_hi);
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r == 1) return $urandom_range(33, 63);
    if (r == 2) return GLYPH_MAX;
    if (r <= 4) return $urandom_range(common_hi + 1, GLYPH_MAX);
    return $urandom_range(1, common_hi);
  endfunction

  // Mostly whole glyphs with random bits, some cut short or unmarked, some noise.
  task automatic queue_random_glyphs(input int target, input int x_hi, input int y_hi);
    glyph_word_t g;
    int queued, pick, cw, ch, nbytes;
    queued = 0;
    while (queued < target) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        g.bits = gceb_pkg::BYTE_W'($urandom);
        g.x = 12'($urandom);
        g.y = 12'($urandom);
        g.w = gceb_pkg::SIZE_FIELD_W'($urandom);
        g.h = gceb_pkg::SIZE_FIELD_W'($urandom);
        g.first = 1'($urandom);
        glyph_words.push_back(g);
        queued++;
      end else begin
        g.w = gceb_pkg::SIZE_FIELD_W'(pick_glyph_size(16));
        g.h = gceb_pkg::SIZE_FIELD_W'(pick_glyph_size(8));
        g.x = 12'($urandom_range(0, x_hi));
        g.y = 12'($urandom_range(0, y_hi));
        cw = (g.w > GLYPH_MAX) ? GLYPH_MAX : g.w;
        ch = (g.h > GLYPH_MAX) ? GLYPH_MAX : g.h;
        nbytes = ((cw + 7) / 8 == 0 ? 1 : (cw + 7) / 8) * (ch == 0 ? 1 : ch);
        if (pick == 1) nbytes = $urandom_range(1, nbytes);
        for (int i = 0; i < nbytes; i++) begin
          g.bits = gceb_pkg::BYTE_W'($urandom);
          g.first = (i == 0) && (pick != 2);
          glyph_words.push_back(g);
          queued++;
        end
      end
    end
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (glyph_words.size() != 0 || s_axis_tvalid || pending_pixels.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [gceb_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [gceb_pkg::COLOR_W-1:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      gceb_pkg::REG_TEXT_COLOR: text_rgb = val;
      gceb_pkg::REG_BACKGROUND_COLOR: back_rgb = val;
      gceb_pkg::REG_TRANSPARENT_BACKGROUND: see_through = val[0];
      gceb_pkg::REG_BUFFER_WIDTH: clip_w = val[gceb_pkg::DIM_W-1:0];
      gceb_pkg::REG_BUFFER_HEIGHT: clip_h = val[gceb_pkg::DIM_W-1:0];
      gceb_pkg::REG_SCANLINE_PIXELS: pitch = val[gceb_pkg::DIM_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_settings(input int text, input int back, input int clear,
                                input int bw, input int bh, input int span);
    wait_idle();
    write_reg(gceb_pkg::REG_TEXT_COLOR, gceb_pkg::COLOR_W'(text));
    write_reg(gceb_pkg::REG_BACKGROUND_COLOR, gceb_pkg::COLOR_W'(back));
    write_reg(gceb_pkg::REG_TRANSPARENT_BACKGROUND, gceb_pkg::COLOR_W'(clear));
    write_reg(gceb_pkg::REG_BUFFER_WIDTH, gceb_pkg::COLOR_W'(bw));
    write_reg(gceb_pkg::REG_BUFFER_HEIGHT, gceb_pkg::COLOR_W'(bh));
    write_reg(gceb_pkg::REG_SCANLINE_PIXELS, gceb_pkg::COLOR_W'(span));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // With the buffer size still zero every pixel is clipped.
    queue_word(8'hff, 0, 0, 8, 1, 1'b1);
    queue_word(8'h00, 0, 0, 8, 1, 1'b0);
    wait_idle();
    write_reg(gceb_pkg::REG_BUFFER_WIDTH, gceb_pkg::COLOR_W'(4096));
    write_reg(gceb_pkg::REG_BUFFER_HEIGHT, gceb_pkg::COLOR_W'(4096));
    write_reg(gceb_pkg::REG_SCANLINE_PIXELS, gceb_pkg::COLOR_W'(4096));

    queue_word(8'ha5, 0, 0, 8, 2, 1'b1);
    queue_word(8'h00, 0, 0, 8, 2, 1'b0);
    // Right and bottom edge: only the first column group lands inside.
    queue_word(8'hff, 4088, 4095, 32, 1, 1'b1);
    queue_word(8'h81, 4088, 4095, 32, 1, 1'b0);
    queue_word(8'hff, 4088, 4095, 32, 1, 1'b0);
    queue_word(8'h0f, 4088, 4095, 32, 1, 1'b0);
    queue_word(8'hff, 10, 10, 0, 0, 1'b1);
    queue_word(8'h55, 10, 10, 0, 0, 1'b0);
    queue_word(8'hff, 0, 0, 63, 63, 1'b1);
    queue_word(8'h3c, 0, 0, 63, 63, 1'b0);
    // Two groups of two rows; the fifth byte wraps back to the start.
    queue_word(8'hff, 100, 200, 9, 2, 1'b1);
    queue_word(8'h7f, 100, 200, 9, 2, 1'b0);
    queue_word(8'h80, 100, 200, 9, 2, 1'b0);
    queue_word(8'h80, 100, 200, 9, 2, 1'b0);
    queue_word(8'hc3, 100, 200, 9, 2, 1'b0);
    queue_word(8'h01, 4095, 0, 1, 1, 1'b1);
    queue_word(8'h80, 4095, 4095, 1, 1, 1'b1);

    apply_settings(24'h123456, 24'habcdef, 1, 4096, 4096, 4096);
    queue_word(8'h5a, 7, 9, 8, 1, 1'b1);
    queue_word(8'h00, 7, 9, 8, 2, 1'b1);
    queue_word(8'hff, 7, 9, 6, 2, 1'b0);

    apply_settings($urandom_range(0, 24'hffffff), $urandom_range(0, 24'hffffff), 0,
                   4096, 4096, 4096);
    queue_random_glyphs(PHASE_WORDS, 4095, 4095);

    apply_settings($urandom_range(0, 24'hffffff), $urandom_range(0, 24'hffffff), 1,
                   $urandom_range(1, 40), $urandom_range(1, 40), $urandom_range(0, 64));
    queue_random_glyphs(PHASE_WORDS, 48, 48);

    apply_settings(24'hffffff, 24'h000000, 0, 4096, 4096, 0);
    queue_random_glyphs(PHASE_WORDS, 4095, 4095);

    apply_settings(24'h000000, 24'hffffff, $urandom_range(0, 1), $urandom_range(1, 4096),
                   $urandom_range(1, 4096), $urandom_range(0, 4096));
    queue_random_glyphs(PHASE_WORDS, 4095, 4095);

    wait_idle();
    if (failures == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

[files.f]
rtl/gceb_pkg.sv
rtl/gceb_cfg_regs.sv
rtl/gceb_glyph_walk.sv
rtl/gceb_clip_stage.sv
rtl/gceb_pixel_emit.sv
rtl/glyph_color_expand_blitter_core.sv
tb/sv/tb_glyph_color_expand_blitter_core.sv
